@@ design/qmml_pkg.sv @@
// qmml_pkg: shared constants and types of the quad motor mixer and limiter
// no dependencies; imported by every module of the block
package qmml_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_MODE = 1'b0,
    REG_MIN_GAS    = 1'b1
  } cfg_reg_e;

  // frame layouts
  typedef enum logic [0:0] {
    FRAME_PLUS = 1'b0,
    FRAME_X    = 1'b1
  } frame_e;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned MotorW  = 8;
  localparam int unsigned InDataW = 4 * FieldW;
  localparam int unsigned OutDataW = 4 * MotorW;

  // throttle pulse at which the base level is zero
  localparam logic [16:0] PulseZero = 17'd1000;
  // top of the limiter window
  localparam logic signed [15:0] UpperLimit = 16'sd200;

  // reciprocal constants, both used with a right shift of RecipShift
  // plus frame: n/5 as n * (ceil(2^18/5) << 3) >> 21
  // x frame:    (2n)/11 as 2n * ceil(2^21/11) >> 21
  localparam int unsigned RecipShift = 21;
  localparam logic [18:0] RecipPlus = 19'd419432;
  localparam logic [18:0] RecipX    = 19'd190651;

  typedef logic signed [FieldW-1:0] corr_t;
  typedef logic [MotorW-1:0]        motor_t;

  // one input item as held in the pipeline
  typedef struct packed {
    corr_t       corr_yaw;
    corr_t       corr_pitch;
    corr_t       corr_roll;
    logic [15:0] throttle_pulse;
  } item_t;

  // corrections plus scaled throttle, between the two compute stages
  typedef struct packed {
    corr_t  corr_yaw;
    corr_t  corr_pitch;
    corr_t  corr_roll;
    motor_t throttle;
  } mix_in_t;

  // four motor commands, motor one in the lowest bits
  typedef struct packed {
    motor_t motor_four;
    motor_t motor_three;
    motor_t motor_two;
    motor_t motor_one;
  } motors_t;

endpackage

@@ design/qmml_throttle.sv @@
// qmml_throttle: scales the throttle pulse to an 8-bit base level
// depends on qmml_pkg; one shared multiplier for both frame divisors
module qmml_throttle (
  input  logic                 frame_mode_i,
  input  logic [15:0]          throttle_pulse_i,
  output qmml_pkg::motor_t     throttle_o
);
  import qmml_pkg::*;

  logic signed [16:0] diff;
  logic               neg;
  logic [16:0]        mag_wide;
  logic [15:0]        mag;
  logic [16:0]        mul_a;
  logic [18:0]        mul_b;
  logic [35:0]        prod;
  logic [7:0]         quot_lo;

  // signed offset from the zero pulse and its magnitude
  assign diff     = signed'({1'b0, throttle_pulse_i} - PulseZero);
  assign neg      = diff[16];
  assign mag_wide = neg ? 17'(-diff) : 17'(diff);
  assign mag      = mag_wide[15:0];

  // x frame divides 2n by 11, plus frame divides n by 5
  always_comb begin
    if (frame_e'(frame_mode_i) == FRAME_X) begin
      mul_a = {mag, 1'b0};
      mul_b = RecipX;
    end else begin
      mul_a = {1'b0, mag};
      mul_b = RecipPlus;
    end
  end

  assign prod    = 36'(mul_a) * 36'(mul_b);
  assign quot_lo = prod[RecipShift +: 8];

  // truncation toward zero, keep the low byte
  assign throttle_o = neg ? 8'(-quot_lo) : quot_lo;

endmodule

@@ design/qmml_mix_limit.sv @@
// qmml_mix_limit: frame mixing, common offset limiter and saturation
// depends on qmml_pkg
module qmml_mix_limit (
  input  logic                 frame_mode_i,
  input  qmml_pkg::motor_t     min_gas_i,
  input  qmml_pkg::mix_in_t    mix_i,
  output qmml_pkg::motors_t    motors_o
);
  import qmml_pkg::*;

  logic [15:0]        t16;
  logic [15:0]        r;
  logic [15:0]        p;
  logic [15:0]        y;
  logic signed [15:0] sum [4];
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic signed [15:0] gas;
  logic signed [18:0] adj;
  logic signed [18:0] res [4];
  motor_t             sat [4];

  assign t16 = {8'd0, mix_i.throttle};
  assign r   = mix_i.corr_roll;
  assign p   = mix_i.corr_pitch;
  assign y   = mix_i.corr_yaw;
  assign gas = signed'({8'd0, min_gas_i});

  // four wrapping sums per frame layout
  always_comb begin
    if (frame_e'(frame_mode_i) == FRAME_X) begin
      sum[0] = signed'(16'(t16 - p + r - y));
      sum[1] = signed'(16'(t16 - p - r + y));
      sum[2] = signed'(16'(t16 + p + r + y));
      sum[3] = signed'(16'(t16 + p - r - y));
    end else begin
      sum[0] = signed'(16'(t16 - p - y));
      sum[1] = signed'(16'(t16 + p - y));
      sum[2] = signed'(16'(t16 - r + y));
      sum[3] = signed'(16'(t16 + r + y));
    end
  end

  // lowest and highest against the window bounds
  always_comb begin
    lo = gas;
    hi = UpperLimit;
    for (int i = 0; i < 4; i++) begin
      if (sum[i] < lo) lo = sum[i];
      if (sum[i] > hi) hi = sum[i];
    end
  end

  // common shift, exact, then clamp to a byte
  assign adj = (19'(gas) - 19'(lo)) + (19'(UpperLimit) - 19'(hi));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = 19'(sum[i]) + adj;
      if (res[i] < 0)            sat[i] = '0;
      else if (res[i] > 19'sd255) sat[i] = '1;
      else                        sat[i] = res[i][7:0];
    end
  end

  assign motors_o.motor_one   = sat[0];
  assign motors_o.motor_two   = sat[1];
  assign motors_o.motor_three = sat[2];
  assign motors_o.motor_four  = sat[3];

endmodule

@@ design/quad_motor_mixer_limiter.sv @@
// quad_motor_mixer_limiter: top level, stream ports, config and pipeline
// depends on qmml_pkg, qmml_throttle and qmml_mix_limit
//
// Usage
//   s_axis carries one control update per transfer: throttle pulse and the
//   roll, pitch and yaw corrections. m_axis returns the four motor commands
//   for that update, one result per input, in order.
//   cfg_we_i writes frame_mode (index 0) or min_gas (index 1) at the clock
//   edge; write only while no update is in flight.
// Pipeline and throughput
//   Three register stages: input register, throttle scaling (one
//   multiplier) into a middle register, then mixing and limiting into the
//   result register. One update is taken every cycle while m_axis drains.
// Reset
//   rst_ni clears all stage valid flags and both config registers
//   (plus frame, min_gas zero). No clearing pass.
// Stalls
//   With m_axis_tready low the result holds; the earlier stages still fill,
//   so up to three updates sit in the block before s_axis_tready drops.
module quad_motor_mixer_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [7:0]                    cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // throttle_pulse[15:0], corr_roll[31:16], corr_pitch[47:32], corr_yaw[63:48]
  input  logic [qmml_pkg::InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // motor_one[7:0], motor_two[15:8], motor_three[23:16], motor_four[31:24]
  output logic [qmml_pkg::OutDataW-1:0] m_axis_tdata
);
  import qmml_pkg::*;

  logic    frame_mode_q;
  motor_t  min_gas_q;

  logic    in_vld_q;
  item_t   in_q;
  logic    mid_vld_q;
  mix_in_t mid_q;
  mix_in_t mid_d;
  logic    out_vld_q;
  motors_t out_q;
  motors_t out_d;

  logic    in_en;
  logic    mid_en;
  logic    out_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= 1'b0;
      min_gas_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_MODE: frame_mode_q <= cfg_wdata_i[0];
        REG_MIN_GAS:    min_gas_q    <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // stage enables, each stage loads when it is empty or drains
  assign out_en        = !out_vld_q || m_axis_tready;
  assign mid_en        = !mid_vld_q || out_en;
  assign in_en         = !in_vld_q || mid_en;
  assign s_axis_tready = in_en;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_en)  in_vld_q  <= s_axis_tvalid;
      if (mid_en) mid_vld_q <= in_vld_q;
      if (out_en) out_vld_q <= mid_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid) in_q  <= item_t'(s_axis_tdata);
    if (mid_en && in_vld_q)     mid_q <= mid_d;
    if (out_en && mid_vld_q)    out_q <= out_d;
  end

  // throttle scaling stage
  qmml_throttle u_throttle (
    .frame_mode_i     (frame_mode_q),
    .throttle_pulse_i (in_q.throttle_pulse),
    .throttle_o       (mid_d.throttle)
  );

  assign mid_d.corr_roll  = in_q.corr_roll;
  assign mid_d.corr_pitch = in_q.corr_pitch;
  assign mid_d.corr_yaw   = in_q.corr_yaw;

  // mixing and limiting stage
  qmml_mix_limit u_mix_limit (
    .frame_mode_i (frame_mode_q),
    .min_gas_i    (min_gas_q),
    .mix_i        (mid_q),
    .motors_o     (out_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ design/qmml_checker.sv @@
// qmml_assert: port-level checks of the quad motor mixer and limiter
// depends on qmml_pkg; bound to quad_motor_mixer_limiter below
module qmml_assert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [qmml_pkg::OutDataW-1:0] m_axis_tdata
);
  import qmml_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // the input side only backs up behind a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // an accepted update has a result on offer once it has passed the input, middle and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##3 m_axis_tvalid)
    else $error("no result three cycles after input transfer");

endmodule

bind quad_motor_mixer_limiter qmml_assert u_qmml_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/qmml_checker.sv @@
// qmml_checker: watches the config port and both stream channels of the mixer,
// predicts the four motor commands of every update and compares them in order
// depends on qmml_pkg
module qmml_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // throttle_pulse[15:0], corr_roll[31:16], corr_pitch[47:32], corr_yaw[63:48]
  input  logic [qmml_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // motor_one[7:0], motor_two[15:8], motor_three[23:16], motor_four[31:24]
  input  logic [qmml_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qmml_pkg::*;

  localparam int PlusDivisor = 5;
  localparam int XMultiplier = 10;
  localparam int XDivisor    = 55;

  localparam string MotorName [4] = '{"motor_one", "motor_two", "motor_three", "motor_four"};

  frame_e      frame_sel;
  motor_t      gas_floor;
  motors_t     motors_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt  = 0;

  // throttle scaling, frame mix and the common-shift limiter
  function automatic motors_t mix_and_limit(item_t upd, frame_e frame, motor_t gas);
    int          pulse_diff;
    int          quotient;
    int          level;
    int          roll;
    int          pitch;
    int          yaw;
    int          low_sum;
    int          high_sum;
    int          shift_amt;
    int          shifted;
    shortint     sums [4];
    motor_t [3:0] cmd;
    pulse_diff = int'(upd.throttle_pulse) - int'(PulseZero);
    // signed division truncates toward zero, only the low byte survives
    if (frame == FRAME_X) quotient = (pulse_diff * XMultiplier) / XDivisor;
    else quotient = pulse_diff / PlusDivisor;
    level = quotient & 255;
    roll  = int'(upd.corr_roll);
    pitch = int'(upd.corr_pitch);
    yaw   = int'(upd.corr_yaw);
    // sums wrap to 16 bits before the limiter
    if (frame == FRAME_X) begin
      sums[0] = shortint'(level - pitch + roll - yaw);
      sums[1] = shortint'(level - pitch - roll + yaw);
      sums[2] = shortint'(level + pitch + roll + yaw);
      sums[3] = shortint'(level + pitch - roll - yaw);
    end else begin
      sums[0] = shortint'(level - pitch - yaw);
      sums[1] = shortint'(level + pitch - yaw);
      sums[2] = shortint'(level - roll + yaw);
      sums[3] = shortint'(level + roll + yaw);
    end
    low_sum  = int'(gas);
    high_sum = int'(UpperLimit);
    foreach (sums[i]) begin
      if (int'(sums[i]) < low_sum) low_sum = int'(sums[i]);
      if (int'(sums[i]) > high_sum) high_sum = int'(sums[i]);
    end
    shift_amt = (int'(gas) - low_sum) + (int'(UpperLimit) - high_sum);
    foreach (sums[i]) begin
      shifted = int'(sums[i]) + shift_amt;
      if (shifted < 0) cmd[i] = '0;
      else if (shifted > 255) cmd[i] = '1;
      else cmd[i] = motor_t'(shifted);
    end
    return motors_t'(cmd);
  endfunction

  // config tracking, prediction on input transfers, comparison on output transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    motor_t [3:0] want;
    motor_t [3:0] got;
    if (!rst_ni) begin
      frame_sel = FRAME_PLUS;
      gas_floor = '0;
      motors_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_FRAME_MODE: frame_sel = frame_e'(cfg_wdata_i[0]);
          REG_MIN_GAS:    gas_floor = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        motors_due.push_back(mix_and_limit(item_t'(s_tdata_i), frame_sel, gas_floor));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (motors_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result transfer, got %h with nothing outstanding",
                   $time, m_tdata_i);
        end else begin
          want = motors_due.pop_front();
          checked_cnt++;
          for (int i = 0; i < 4; i++) begin
            if (want[i] !== got[i]) begin
              mismatch_cnt++;
              $display("%0t: %s mismatch, expected %0d, actual %0d",
                       $time, MotorName[i], want[i], got[i]);
            end
          end
        end
      end
    end
    fail_count_o <= mismatch_cnt;
    pending_o    <= motors_due.size();
    checked_o    <= checked_cnt;
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus, reset and verdict for quad_motor_mixer_limiter
// depends on qmml_pkg, the block under test and qmml_checker
// directed corner updates, then random phases over several frame and min_gas settings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qmml_pkg::*;

  localparam int unsigned QuietLimit    = 500;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned UpdatesPerRun = 225;
  localparam int unsigned IdlePct       = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [0:0]          cfg_addr_i;
  logic [7:0]          cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                calm_phase = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned updates_sent = 0;
  int unsigned settings_used = 0;

  quad_motor_mixer_limiter u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  qmml_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side back-pressure, none during the calm phase
  always @(posedge clk_i) begin
    m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= IdlePct);
  end

  function automatic item_t make_update(logic [15:0] pulse, int roll, int pitch, int yaw);
    item_t upd;
    upd.throttle_pulse = pulse;
    upd.corr_roll      = corr_t'(roll);
    upd.corr_pitch     = corr_t'(pitch);
    upd.corr_yaw       = corr_t'(yaw);
    return upd;
  endfunction

  // mostly small corrections so the limiter works near its window, some wide ones
  function automatic corr_t random_corr();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return corr_t'(int'($urandom_range(0, 300)) - 150);
    if (pick < 80) return corr_t'(int'($urandom_range(0, 4000)) - 2000);
    if (pick < 92) return corr_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic item_t random_update();
    item_t       upd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) upd.throttle_pulse = 16'($urandom_range(940, 2100));
    else if (pick < 90) upd.throttle_pulse = 16'($urandom);
    else begin
      case ($urandom_range(0, 4))
        0:       upd.throttle_pulse = 16'd0;
        1:       upd.throttle_pulse = 16'd999;
        2:       upd.throttle_pulse = 16'd1000;
        3:       upd.throttle_pulse = 16'd2000;
        default: upd.throttle_pulse = 16'hffff;
      endcase
    end
    upd.corr_roll  = random_corr();
    upd.corr_pitch = random_corr();
    upd.corr_yaw   = random_corr();
    return upd;
  endfunction

  // one input transfer with random gaps ahead of it
  task automatic send_update(item_t upd);
    while (!calm_phase && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= upd;
    do @(posedge clk_i); while (!s_axis_tready);
    updates_sent++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_config(frame_e frame, motor_t gas);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_FRAME_MODE;
    cfg_wdata_i <= 8'(frame);
    @(posedge clk_i);
    cfg_addr_i  <= REG_MIN_GAS;
    cfg_wdata_i <= gas;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // no transfer of any kind for too long ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    frame_e frame;
    motor_t gas;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_FRAME_MODE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: plus frame, no floor
    send_update(make_update(16'd1000, 0, 0, 0));
    send_update(make_update(16'd2000, 0, 0, 0));
    send_update(make_update(16'd0, 0, 0, 0));          // negative base keeps low byte
    send_update(make_update(16'hffff, 0, 0, 0));
    send_update(make_update(16'd999, 0, 0, 0));        // truncates to zero
    send_update(make_update(16'd994, 0, 0, 0));        // minus one, reads as 255
    send_update(make_update(16'd1500, 32767, -32768, 32767));   // sums wrap
    send_update(make_update(16'd1500, -32768, 32767, -32768));
    send_update(make_update(16'd1200, 50, -50, 30));
    send_update(make_update(16'd1500, 0, 0, 300));     // over both bounds by the same amount, no net shift
    send_update(make_update(16'd1000, -100, 100, -100));  // raised from below
    send_update(make_update(16'd2000, 5000, -5000, 5000)); // both bounds at once

    // x frame with a floor above the upper limit
    load_config(FRAME_X, 8'd201);
    send_update(make_update(16'd1000, 0, 0, 0));
    send_update(make_update(16'd1055, 0, 0, 0));
    send_update(make_update(16'd945, 0, 0, 0));
    send_update(make_update(16'd1006, 0, 0, 0));
    send_update(make_update(16'd0, 10, 20, -30));
    send_update(make_update(16'hffff, -1, -1, -1));
    send_update(make_update(16'd1500, 32767, 32767, 32767));
    send_update(make_update(16'd2000, -32768, -32768, -32768));
    send_update(make_update(16'd1500, 10, 20, -30));

    // random phases, extremes of min_gas first, one phase without idling
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      frame = (ph % 2 == 0) ? FRAME_PLUS : FRAME_X;
      case (ph)
        0:       gas = 8'd0;
        1:       gas = 8'd255;
        2:       gas = 8'd200;
        3:       gas = 8'd0;
        default: gas = 8'($urandom_range(0, 255));
      endcase
      load_config(frame, gas);
      calm_phase <= (ph == 3);
      for (int unsigned n = 0; n < UpdatesPerRun; n++)
        send_update(random_update());
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d updates over %0d frame and floor settings, %0d results compared",
             updates_sent, settings_used + 1, checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ quad_motor_mixer_limiter.f @@
design/qmml_pkg.sv
design/qmml_throttle.sv
design/qmml_mix_limit.sv
design/quad_motor_mixer_limiter.sv
design/qmml_checker.sv
tb/qmml_checker.sv
tb/tb_top.sv
